FILE: design/ackermann_wheel_kinematics_macros.svh
// Assertion helpers for the top-level design file.
`ifndef ACKERMANN_WHEEL_KINEMATICS_MACROS_SVH
`define ACKERMANN_WHEEL_KINEMATICS_MACROS_SVH

// Plain concurrent check on the rising clock edge, off during reset.
`define AWK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that holds from the first clock edge, reset included.
`define AWK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: design/awk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package awk_pkg;

  // datapath widths
  localparam int SW = 34;  // sin/cos CORDIC x, y
  localparam int ZW = 34;  // angle accumulators, rad * 2^30
  localparam int PW = 48;  // products and Ackermann terms
  localparam int MW = 47;  // magnitudes of terms
  localparam int VW = 51;  // vectoring CORDIC x, y
  localparam int NW = 64;  // dividend
  localparam int QB = 17;  // quotient bits
  localparam int LW = 24;  // low split of term magnitude
  localparam int HW = MW - LW;

  localparam logic [13:0] WHEELBASE_RST = 14'd2500;
  localparam logic [13:0] TRACK_RST     = 14'd1500;

  localparam logic signed [ZW-1:0] ANG_HALF_PI = 34'sd1686629713;
  localparam logic signed [ZW-1:0] ANG_PI      = 34'sd3373259426;
  localparam logic signed [SW-1:0] ONE_Q30     = 34'sd1073741824;

  localparam logic signed [15:0] SPD_MAX = 16'sh7fff;
  localparam logic signed [15:0] SPD_MIN = 16'sh8000;

  typedef enum logic [0:0] {
    CFG_WHEELBASE = 1'b0,
    CFG_TRACK     = 1'b1
  } cfg_idx_e;

  // carried along the sin/cos CORDIC
  typedef struct packed {
    logic signed [15:0] v;
    logic               flip;
    logic               zero;
  } sc_t;

  // per-side speed terms carried along the vectoring CORDIC
  typedef struct packed {
    logic [16+LW-1:0] plo;
    logic [16+HW-1:0] phi;
    logic             neg;
    logic             tzero;
    logic             tneg;
  } side_t;

  typedef struct packed {
    logic signed [15:0] v;
    logic [MW-1:0]      dabs;
    logic               dzero;
    logic               yzero;
    side_t [1:0]        sd;
  } sp_t;

  // per-side flags carried along the divider
  typedef struct packed {
    logic neg;
    logic tzero;
    logic tneg;
    logic ovf;
  } dsd_t;

  typedef struct packed {
    logic signed [15:0] v;
    logic [MW-1:0]      dabs;
    logic               dzero;
    logic [1:0][15:0]   ang;
    dsd_t [1:0]         sd;
  } dv_t;

  // arctangent of 2^-i, rad * 2^30
  function automatic logic signed [ZW-1:0] atan_at(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = 34'sd843314856;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043836;
      3:  r = 34'sd133525158;
      4:  r = 34'sd67021686;
      5:  r = 34'sd33543515;
      6:  r = 34'sd16775850;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194282;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048575;
      11: r = 34'sd524287;
      12: r = 34'sd262143;
      13: r = 34'sd131071;
      14: r = 34'sd65535;
      15: r = 34'sd32767;
      16: r = 34'sd16383;
      17: r = 34'sd8191;
      18: r = 34'sd4095;
      19: r = 34'sd2047;
      20: r = 34'sd1023;
      21: r = 34'sd511;
      22: r = 34'sd255;
      23: r = 34'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/ackermann_wheel_kinematics.sv
// Throughput: one transaction per cycle while the output is not stalled; each CORDIC
// step and each of the 17 divider bits is its own register stage, so the pipeline takes
// a new item every cycle when the output is not stalled.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
// Reset (async, active low) clears all stage valid bits and loads wheelbase 2500 mm
// and track 1500 mm.
`timescale 1ns / 1ps
`default_nettype none
`include "ackermann_wheel_kinematics_macros.svh"
module ackermann_wheel_kinematics #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [13:0] cfg_data_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [15:0] speed_cmd, [31:16] steer_cmd
  input  wire logic [31:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [15:0] front_left_angle, [31:16] front_right_angle, [47:32] front_left_speed,
  // [63:48] front_right_speed, [79:64] rear_left_speed, [95:80] rear_right_speed
  output logic [95:0]      m_axis_tdata_o,
  // [0] saturated
  output logic [0:0]       m_axis_tuser_o
);

  localparam int N  = CORDIC_STEPS;
  localparam int SW = awk_pkg::SW;
  localparam int ZW = awk_pkg::ZW;
  localparam int PW = awk_pkg::PW;
  localparam int MW = awk_pkg::MW;
  localparam int VW = awk_pkg::VW;
  localparam int NW = awk_pkg::NW;
  localparam int QB = awk_pkg::QB;
  localparam int LW = awk_pkg::LW;

  logic adv;

  // configuration registers
  logic [13:0] l_q, t_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_q <= awk_pkg::WHEELBASE_RST;
      t_q <= awk_pkg::TRACK_RST;
    end else if (cfg_we_i) begin
      case (awk_pkg::cfg_idx_e'(cfg_idx_i))
        awk_pkg::CFG_WHEELBASE: l_q <= cfg_data_i;
        awk_pkg::CFG_TRACK:     t_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid bits of every stage
  logic [N:0]    sc_vld_q;
  logic          b_vld_q, c_vld_q, d_vld_q;
  logic [N:0]    vec_vld_q;
  logic          f_vld_q;
  logic [QB:0]   div_vld_q;
  logic          h_vld_q;

  assign adv             = !h_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = h_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_vld_q  <= '0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      d_vld_q   <= 1'b0;
      vec_vld_q <= '0;
      f_vld_q   <= 1'b0;
      div_vld_q <= '0;
      h_vld_q   <= 1'b0;
    end else if (adv) begin
      sc_vld_q  <= {sc_vld_q[N-1:0], s_axis_tvalid_i};
      b_vld_q   <= sc_vld_q[N];
      c_vld_q   <= b_vld_q;
      d_vld_q   <= c_vld_q;
      vec_vld_q <= {vec_vld_q[N-1:0], d_vld_q};
      f_vld_q   <= vec_vld_q[N];
      div_vld_q <= {div_vld_q[QB-1:0], f_vld_q};
      h_vld_q   <= div_vld_q[QB];
    end
  end

  // stage A: take the item, scale the angle to 2^30 and fold beyond pi/2
  logic signed [SW-1:0] sc_x_q [N+1];
  logic signed [SW-1:0] sc_y_q [N+1];
  logic signed [ZW-1:0] sc_z_q [N+1];
  awk_pkg::sc_t         sc_c_q [N+1];

  logic signed [15:0]   steer;
  logic signed [ZW-1:0] zraw, za_d;
  awk_pkg::sc_t         ca_d;

  always_comb begin
    steer   = s_axis_tdata_i[31:16];
    zraw    = {{(ZW-32){steer[15]}}, steer, 16'b0};
    ca_d.v    = s_axis_tdata_i[15:0];
    ca_d.zero = (steer == 16'sd0);
    ca_d.flip = 1'b0;
    za_d      = zraw;
    if (zraw > awk_pkg::ANG_HALF_PI) begin
      za_d      = zraw - awk_pkg::ANG_PI;
      ca_d.flip = 1'b1;
    end else if (zraw < -awk_pkg::ANG_HALF_PI) begin
      za_d      = zraw + awk_pkg::ANG_PI;
      ca_d.flip = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sc_x_q[0] <= awk_pkg::ONE_Q30;
      sc_y_q[0] <= '0;
      sc_z_q[0] <= za_d;
      sc_c_q[0] <= ca_d;
    end
  end

  // rotation CORDIC, one step per stage
  for (genvar i = 0; i < N; i++) begin : g_sc
    logic signed [SW-1:0] x_d, y_d;
    logic signed [ZW-1:0] z_d;
    always_comb begin
      if (!sc_z_q[i][ZW-1]) begin
        x_d = sc_x_q[i] - (sc_y_q[i] >>> i);
        y_d = sc_y_q[i] + (sc_x_q[i] >>> i);
        z_d = sc_z_q[i] - awk_pkg::atan_at(i);
      end else begin
        x_d = sc_x_q[i] + (sc_y_q[i] >>> i);
        y_d = sc_y_q[i] - (sc_x_q[i] >>> i);
        z_d = sc_z_q[i] + awk_pkg::atan_at(i);
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sc_x_q[i+1] <= x_d;
        sc_y_q[i+1] <= y_d;
        sc_z_q[i+1] <= z_d;
        sc_c_q[i+1] <= sc_c_q[i];
      end
    end
  end

  // stage B: undo the fold, zero steer takes sin 0 and cos 1
  logic signed [SW-1:0] s_q, c_q, s_d, c_d;
  logic signed [15:0]   vb_q, vc_q, vd_q;

  always_comb begin
    if (sc_c_q[N].zero) begin
      s_d = '0;
      c_d = awk_pkg::ONE_Q30;
    end else if (sc_c_q[N].flip) begin
      s_d = -sc_y_q[N];
      c_d = -sc_x_q[N];
    end else begin
      s_d = sc_y_q[N];
      c_d = sc_x_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q  <= s_d;
      c_q  <= c_d;
      vb_q <= sc_c_q[N].v;
    end
  end

  // stage C: geometry products
  logic signed [SW+14:0] lc_m, ls_m, ts_m;
  logic signed [PW-1:0]  lc_q, ls_q, ts_q;

  always_comb begin
    lc_m = c_q * $signed({1'b0, l_q});
    ls_m = s_q * $signed({1'b0, l_q});
    ts_m = s_q * $signed({1'b0, t_q});
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lc_q <= PW'(lc_m);
      ls_q <= PW'(ls_m);
      ts_q <= PW'(ts_m);
      vc_q <= vb_q;
    end
  end

  // stage D: Ackermann terms
  logic signed [PW-1:0] den_q, num_q, pl_q, mr_q, den_d;

  assign den_d = lc_q <<< 1;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      den_q <= den_d;
      num_q <= ls_q <<< 1;
      pl_q  <= den_d + ts_q;
      mr_q  <= den_d - ts_q;
      vd_q  <= vc_q;
    end
  end

  // stage E: vectoring setup and speed partial products
  logic signed [VW-1:0] vx_q [2][N+1];
  logic signed [VW-1:0] vy_q [2][N+1];
  logic signed [ZW-1:0] vz_q [2][N+1];
  awk_pkg::sp_t         vc_c_q [N+1];

  logic signed [PW-1:0] term   [2];
  logic signed [VW-1:0] ex_d   [2];
  logic signed [VW-1:0] ey_d   [2];
  logic [PW-1:0]        tabs   [2];
  logic [PW-1:0]        dabs_w;
  logic [16:0]          vabs;
  awk_pkg::sp_t         ce_d;

  always_comb begin
    term[0] = pl_q;
    term[1] = mr_q;
    vabs    = vd_q[15] ? 17'(-$signed({vd_q[15], vd_q})) : {1'b0, vd_q};
    dabs_w  = den_q[PW-1] ? PW'(-den_q) : PW'(den_q);
    ce_d.v     = vd_q;
    ce_d.dabs  = dabs_w[MW-1:0];
    ce_d.dzero = (den_q == '0);
    ce_d.yzero = (num_q == '0);
    for (int k = 0; k < 2; k++) begin
      tabs[k] = term[k][PW-1] ? PW'(-term[k]) : PW'(term[k]);
      if (term[k][PW-1]) begin
        ex_d[k] = -VW'(term[k]);
        ey_d[k] = -VW'(num_q);
      end else begin
        ex_d[k] = VW'(term[k]);
        ey_d[k] = VW'(num_q);
      end
      ce_d.sd[k].plo   = vabs * tabs[k][LW-1:0];
      ce_d.sd[k].phi   = vabs * tabs[k][MW-1:LW];
      ce_d.sd[k].tneg  = term[k][PW-1];
      ce_d.sd[k].tzero = (term[k] == '0);
      ce_d.sd[k].neg   = vd_q[15] ^ term[k][PW-1] ^ den_q[PW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 2; k++) begin
        vx_q[k][0] <= ex_d[k];
        vy_q[k][0] <= ey_d[k];
        vz_q[k][0] <= '0;
      end
      vc_c_q[0] <= ce_d;
    end
  end

  // vectoring CORDIC for both sides, one step per stage
  for (genvar i = 0; i < N; i++) begin : g_vec
    for (genvar k = 0; k < 2; k++) begin : g_side
      logic signed [VW-1:0] x_d, y_d;
      logic signed [ZW-1:0] z_d;
      always_comb begin
        if (!vy_q[k][i][VW-1]) begin
          x_d = vx_q[k][i] + (vy_q[k][i] >>> i);
          y_d = vy_q[k][i] - (vx_q[k][i] >>> i);
          z_d = vz_q[k][i] + awk_pkg::atan_at(i);
        end else begin
          x_d = vx_q[k][i] - (vy_q[k][i] >>> i);
          y_d = vy_q[k][i] + (vx_q[k][i] >>> i);
          z_d = vz_q[k][i] - awk_pkg::atan_at(i);
        end
      end
      always_ff @(posedge clk_i) begin
        if (adv) begin
          vx_q[k][i+1] <= x_d;
          vy_q[k][i+1] <= y_d;
          vz_q[k][i+1] <= z_d;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) vc_c_q[i+1] <= vc_c_q[i];
    end
  end

  // stage F: round angles, form rounded dividends
  logic [NW-1:0]        n_q [2];
  logic [NW-1:0]        n_d [2];
  awk_pkg::dv_t         cf_q, cf_d;
  logic signed [ZW-1:0] zr  [2];

  always_comb begin
    cf_d.v     = vc_c_q[N].v;
    cf_d.dabs  = vc_c_q[N].dabs;
    cf_d.dzero = vc_c_q[N].dzero;
    for (int k = 0; k < 2; k++) begin
      zr[k]          = vz_q[k][N] + ZW'(32768);
      cf_d.ang[k]    = vc_c_q[N].yzero ? 16'h0 : zr[k][31:16];
      cf_d.sd[k].neg   = vc_c_q[N].sd[k].neg;
      cf_d.sd[k].tzero = vc_c_q[N].sd[k].tzero;
      cf_d.sd[k].tneg  = vc_c_q[N].sd[k].tneg;
      cf_d.sd[k].ovf   = 1'b0;
      n_d[k] = (NW'(vc_c_q[N].sd[k].phi) << LW) + NW'(vc_c_q[N].sd[k].plo)
             + NW'(vc_c_q[N].dabs >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n_q  <= n_d;
      cf_q <= cf_d;
    end
  end

  // stage G: overflow check and divider seed
  logic [MW-1:0] rem_q  [2][QB+1];
  logic [QB-1:0] q_q    [2][QB+1];
  logic [QB-1:0] nlo_q  [2][QB+1];
  awk_pkg::dv_t  dv_c_q [QB+1];
  awk_pkg::dv_t  cg_d;

  always_comb begin
    cg_d = cf_q;
    for (int k = 0; k < 2; k++) begin
      cg_d.sd[k].ovf = (n_q[k][NW-1:QB] >= cf_q.dabs);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 2; k++) begin
        rem_q[k][0] <= n_q[k][NW-1:QB];
        q_q[k][0]   <= '0;
        nlo_q[k][0] <= n_q[k][QB-1:0];
      end
      dv_c_q[0] <= cg_d;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < QB; j++) begin : g_div
    for (genvar k = 0; k < 2; k++) begin : g_side
      logic [MW:0]   sh, df;
      logic          ge;
      logic [MW-1:0] rem_d;
      always_comb begin
        sh    = {rem_q[k][j], nlo_q[k][j][QB-1-j]};
        df    = sh - {1'b0, dv_c_q[j].dabs};
        ge    = (sh >= {1'b0, dv_c_q[j].dabs});
        rem_d = ge ? df[MW-1:0] : sh[MW-1:0];
      end
      always_ff @(posedge clk_i) begin
        if (adv) begin
          rem_q[k][j+1] <= rem_d;
          q_q[k][j+1]   <= {q_q[k][j][QB-2:0], ge};
          nlo_q[k][j+1] <= nlo_q[k][j];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) dv_c_q[j+1] <= dv_c_q[j];
    end
  end

  // stage H: sign, special cases and saturation into the output register
  logic signed [15:0] spd_q [2];
  logic signed [15:0] spd_d [2];
  logic [1:0][15:0]   ang_q;
  logic               sat_q, sat_d;
  awk_pkg::dv_t       ch;
  logic [QB-1:0]      qv;

  always_comb begin
    ch    = dv_c_q[QB];
    sat_d = 1'b0;
    for (int k = 0; k < 2; k++) begin
      qv = q_q[k][QB];
      if (ch.dzero) begin
        if (ch.sd[k].tzero) begin
          spd_d[k] = ch.v;
        end else if (ch.v == 16'sd0) begin
          spd_d[k] = '0;
        end else begin
          sat_d    = 1'b1;
          spd_d[k] = (ch.v[15] != ch.sd[k].tneg) ? awk_pkg::SPD_MIN : awk_pkg::SPD_MAX;
        end
      end else if (ch.sd[k].ovf) begin
        sat_d    = 1'b1;
        spd_d[k] = ch.sd[k].neg ? awk_pkg::SPD_MIN : awk_pkg::SPD_MAX;
      end else if (ch.sd[k].neg) begin
        if (qv > QB'(32768)) begin
          sat_d    = 1'b1;
          spd_d[k] = awk_pkg::SPD_MIN;
        end else begin
          spd_d[k] = 16'(QB'(0) - qv);
        end
      end else begin
        if (qv > QB'(32767)) begin
          sat_d    = 1'b1;
          spd_d[k] = awk_pkg::SPD_MAX;
        end else begin
          spd_d[k] = qv[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      spd_q <= spd_d;
      ang_q <= ch.ang;
      sat_q <= sat_d;
    end
  end

  assign m_axis_tdata_o = {spd_q[1], spd_q[0], spd_q[1], spd_q[0], ang_q[1], ang_q[0]};
  assign m_axis_tuser_o = sat_q;

  // checks
  `AWK_ASSERT(a_rear_matches_front,
    m_axis_tvalid_o |-> (m_axis_tdata_o[79:64] == m_axis_tdata_o[47:32]) &&
                        (m_axis_tdata_o[95:80] == m_axis_tdata_o[63:48]),
    "rear wheel speeds differ from the front terms")
  `AWK_ASSERT(a_sat_at_full_scale,
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |->
      (m_axis_tdata_o[47:32] == 16'h7fff) || (m_axis_tdata_o[47:32] == 16'h8000) ||
      (m_axis_tdata_o[63:48] == 16'h7fff) || (m_axis_tdata_o[63:48] == 16'h8000),
    "saturated flag without a clipped speed")
  `AWK_ASSERT(a_stall_freezes_pipe,
    !adv |=> $stable({sc_vld_q, b_vld_q, c_vld_q, d_vld_q, vec_vld_q, f_vld_q,
                      div_vld_q, h_vld_q}),
    "pipeline moved during an output stall")

endmodule
`default_nettype wire
